/* hw/rtl/plt_pkg.sv */
// ----------------------------------------------------------------------------
// plt_pkg
// Shared types and constants for the peer link table: command codes, beat
// structs for both channels and the stored entry layout.
// ----------------------------------------------------------------------------
package plt_pkg;

  localparam int unsigned LINK_ENTRIES_DEF = 16;
  localparam int unsigned LINK_ENTRIES_MAX = 192;

  localparam logic [7:0] LOCAL_BASE = 8'hC0;
  localparam logic [7:0] NO_LINK    = 8'hFF;
  localparam logic [23:0] ADDR_NONE = 24'h000000;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [5:0]  local_chan;
    logic [23:0] peer_address;
    logic [7:0]  peer_chan;
  } in_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] link_id;
    logic       dirty;
  } out_t;

  // one stored link, 38 bits
  typedef struct packed {
    logic [5:0]  local_chan;
    logic [23:0] peer_address;
    logic [7:0]  peer_chan;
  } entry_t;

endpackage

/* hw/rtl/plt_store.sv */
// ----------------------------------------------------------------------------
// plt_store
// Link entry memory: one write port, one registered read port, and a valid
// bit per entry so that reset frees every entry at once. An entry that is
// not valid reads as all zero.
// ----------------------------------------------------------------------------
module plt_store
  import plt_pkg::*;
#(
  parameter int unsigned LINK_ENTRIES = LINK_ENTRIES_DEF,
  parameter int unsigned IDX_W        = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] rd_idx,
  output entry_t           rd_entry,
  input  logic             wr_en,
  input  logic             clr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  entry_t           wr_entry
);

  entry_t                  mem [LINK_ENTRIES];
  logic [LINK_ENTRIES-1:0] vld_r;
  logic [LINK_ENTRIES-1:0] vld_nxt;
  entry_t                  rd_data_r;
  logic                    rd_vld_r;

  always_comb begin
    vld_nxt = vld_r;
    if (wr_en) begin
      vld_nxt[wr_idx] = 1'b1;
    end
    if (clr_en) begin
      vld_nxt[wr_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      vld_r    <= vld_nxt;
      rd_vld_r <= vld_r[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
    rd_data_r <= mem[rd_idx];
  end

  assign rd_entry = rd_vld_r ? rd_data_r : '0;

endmodule

/* hw/rtl/peer_link_table.sv */
// ----------------------------------------------------------------------------
// peer_link_table
// Table of peer links with first-free insert, associative lookup and remove.
// ----------------------------------------------------------------------------
// One command beat in, one result beat out. The block scans its entries one
// per cycle through a single compare unit, so a command that searches goes
// from acceptance through the registered read of each entry and its
// compare, one entry compared per cycle, to the commit of its result; the
// scan stops early at the first hit. A lookup or remove of a local id
// (address and peer channel both zero) and the unused command skip the scan
// and commit directly. in_stall is high from acceptance until the result has
// been moved into the output register; the output register lets the next
// command in while a result beat is still held by out_stall. Reset frees
// every entry at once through per-entry valid bits: no clearing pass.
// Adds write the lowest entry whose address is zero and do not look for
// duplicates; a full table answers ok = 0, link_id = 0xFF. Lookups answer
// the lowest exact match, 0xC0 + local_chan for a local id, or 0xFF. The
// dirty bit is sticky from the first successful add or remove.
// ----------------------------------------------------------------------------
module peer_link_table
  import plt_pkg::*;
#(
  parameter int unsigned LINK_ENTRIES = LINK_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int unsigned IDX_W = (LINK_ENTRIES > 1) ? $clog2(LINK_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINK_ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  in_t              req_r, req_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             cmp_live_r, cmp_live_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic             flag_r, flag_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;

  entry_t rd_entry;
  entry_t key;
  logic   in_fire;
  logic   is_local;
  logic   hit;
  logic   commit;
  logic   wr_en;
  logic   clr_en;
  out_t   res;
  logic [7:0] local_id;
  logic [7:0] idx_id;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign key = '{local_chan:   req_r.local_chan,
                 peer_address: req_r.peer_address,
                 peer_chan:    req_r.peer_chan};

  // local id: address and peer channel both zero (lookup and remove only)
  assign is_local = (req_r.cmd != CMD_ADD) && (req_r.peer_address == ADDR_NONE) &&
                    (req_r.peer_chan == '0);

  // shared compare unit: free slot for an add, exact match otherwise
  assign hit = (req_r.cmd == CMD_ADD) ? (rd_entry.peer_address == ADDR_NONE)
                                      : (rd_entry == key);

  assign local_id = LOCAL_BASE + {2'b00, req_r.local_chan};
  assign idx_id   = 8'(hit_idx_r);

  always_comb begin
    res = '{ok: 1'b0, link_id: NO_LINK, dirty: flag_r};
    unique case (req_r.cmd)
      CMD_ADD: begin
        res.ok      = found_r;
        res.link_id = found_r ? idx_id : NO_LINK;
        res.dirty   = flag_r | found_r;
      end
      CMD_REMOVE: begin
        res.ok      = found_r;
        res.link_id = is_local ? local_id : (found_r ? idx_id : NO_LINK);
        res.dirty   = flag_r | found_r;
      end
      CMD_LOOKUP: begin
        res.ok      = is_local | found_r;
        res.link_id = is_local ? local_id : (found_r ? idx_id : NO_LINK);
      end
      CMD_NOP: begin
        res.ok      = 1'b0;
        res.link_id = NO_LINK;
      end
      default: begin
        res.ok      = 1'b0;
        res.link_id = NO_LINK;
      end
    endcase
  end

  assign commit = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign wr_en  = commit && (req_r.cmd == CMD_ADD) && found_r;
  assign clr_en = commit && (req_r.cmd == CMD_REMOVE) && found_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_live_nxt  = cmp_live_r;
    found_nxt     = found_r;
    hit_idx_nxt   = hit_idx_r;
    flag_nxt      = flag_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          req_nxt      = in_data;
          rd_idx_nxt   = '0;
          cmp_live_nxt = 1'b0;
          found_nxt    = 1'b0;
          if ((in_data.cmd == CMD_NOP) ||
              ((in_data.cmd != CMD_ADD) && (in_data.peer_address == ADDR_NONE) &&
               (in_data.peer_chan == '0))) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // read pipeline: address issued now, compared next cycle
        cmp_live_nxt = 1'b1;
        cmp_idx_nxt  = rd_idx_r;
        if (rd_idx_r != LAST_IDX) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        if (cmp_live_r) begin
          if (hit) begin
            found_nxt   = 1'b1;
            hit_idx_nxt = cmp_idx_r;
            state_nxt   = ST_DONE;
          end else if (cmp_idx_r == LAST_IDX) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (commit) begin
          out_nxt       = res;
          out_valid_nxt = 1'b1;
          flag_nxt      = res.dirty;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_idx_r    <= '0;
      cmp_live_r  <= 1'b0;
      found_r     <= 1'b0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_idx_r    <= rd_idx_nxt;
      cmp_live_r  <= cmp_live_nxt;
      found_r     <= found_nxt;
      flag_r      <= flag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    hit_idx_r <= hit_idx_nxt;
    out_r     <= out_nxt;
  end

  plt_store #(
    .LINK_ENTRIES (LINK_ENTRIES),
    .IDX_W        (IDX_W)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (rd_idx_r),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .clr_en   (clr_en),
    .wr_idx   (hit_idx_r),
    .wr_entry (key)
  );

endmodule

/* hw/rtl/plt_checker.sv */
// ----------------------------------------------------------------------------
// plt_props
// Port-level checks for the peer link table, bound to the top level.
// ----------------------------------------------------------------------------
module plt_props
  import plt_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  logic seen_dirty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_dirty_r <= 1'b0;
    end else if (out_valid && !out_stall && out_data.dirty) begin
      seen_dirty_r <= 1'b1;
    end
  end

  // held result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // one command at a time: busy straight after a command is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("command accepted while previous one in flight");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  // dirty is sticky once delivered
  a_dirty_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_dirty_r |-> out_data.dirty)
    else $error("dirty flag dropped");

endmodule

bind peer_link_table plt_props u_plt_props (.*);

/* verif/plt_checker.sv */
// ----------------------------------------------------------------------------
// plt_checker
// Scoreboard for the peer link table: keeps a shadow copy of the links,
// predicts one result beat per command beat and compares results in order.
// ----------------------------------------------------------------------------
module plt_checker
  import plt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_t        out_data,
  output int unsigned fail_count,
  output int unsigned pending
);

  localparam int unsigned N_LINKS = LINK_ENTRIES_DEF;

  entry_t      shadow_links [N_LINKS];
  logic        shadow_dirty;
  out_t        expected_q [$];
  int unsigned mismatches = 0;

  // lowest exact match, LOCAL_BASE + channel for a local id, else NO_LINK
  function automatic logic [7:0] resolve_link(input in_t c, output logic is_local);
    int i;
    is_local = (c.peer_address == ADDR_NONE) && (c.peer_chan == 8'd0);
    if (is_local) return LOCAL_BASE + {2'b00, c.local_chan};
    for (i = 0; i < N_LINKS; i++) begin
      if (shadow_links[i].local_chan == c.local_chan &&
          shadow_links[i].peer_address == c.peer_address &&
          shadow_links[i].peer_chan == c.peer_chan) return 8'(i);
    end
    return NO_LINK;
  endfunction

  function automatic out_t predict_result(input in_t c);
    out_t       r;
    logic       is_local;
    logic [7:0] id;
    int         i;
    r.ok      = 1'b0;
    r.link_id = NO_LINK;
    case (c.cmd)
      CMD_ADD: begin
        // first free slot, no duplicate check
        for (i = 0; i < N_LINKS; i++) begin
          if (shadow_links[i].peer_address == ADDR_NONE) begin
            shadow_links[i].local_chan   = c.local_chan;
            shadow_links[i].peer_address = c.peer_address;
            shadow_links[i].peer_chan    = c.peer_chan;
            shadow_dirty = 1'b1;
            r.ok         = 1'b1;
            r.link_id    = 8'(i);
            break;
          end
        end
      end
      CMD_REMOVE: begin
        id        = resolve_link(c, is_local);
        r.link_id = id;
        if (!is_local && id != NO_LINK) begin
          shadow_links[id] = '0;
          shadow_dirty     = 1'b1;
          r.ok             = 1'b1;
        end
      end
      CMD_LOOKUP: begin
        id        = resolve_link(c, is_local);
        r.link_id = id;
        // local channel 63 gives 0xFF yet still counts as found
        r.ok      = is_local || (id != NO_LINK);
      end
      default: ;
    endcase
    r.dirty = shadow_dirty;
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      foreach (shadow_links[k]) shadow_links[k] = '0;
      shadow_dirty = 1'b0;
      expected_q.delete();
    end else begin
      // result side first; a command taken this edge cannot answer yet
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result beat: ok=%0d link_id=%0h dirty=%0d",
                 out_data.ok, out_data.link_id, out_data.dirty);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (out_data.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, out_data.ok);
            mismatches++;
          end
          if (out_data.link_id !== want.link_id) begin
            $error("link_id: expected %0h, got %0h", want.link_id, out_data.link_id);
            mismatches++;
          end
          if (out_data.dirty !== want.dirty) begin
            $error("dirty: expected %0d, got %0d", want.dirty, out_data.dirty);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) expected_q.push_back(predict_result(in_data));
    end
    fail_count <= mismatches;
    pending    <= expected_q.size();
  end

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the peer link table: directed link add, remove and
// lookup beats, then random phases built around a pool of known links, with
// random idling and stalling on both channels; checking lives in plt_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import plt_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  int unsigned fail_count;
  int unsigned pending;

  // quiet phases: neither side idles, so beats run back to back
  bit          quiet = 1'b0;
  int unsigned rx_beats = 0;
  bit          long_hold_done = 1'b0;

  // links recently offered for adding; lookups and removes mostly aim here
  in_t         link_pool [$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  peer_link_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  plt_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic in_t link_cmd(cmd_t k, logic [5:0] lc, logic [23:0] a,
                                   logic [7:0] pc);
    in_t c;
    c.cmd          = k;
    c.local_chan   = lc;
    c.peer_address = a;
    c.peer_chan    = pc;
    return c;
  endfunction

  // a new link; small addresses are common so that lookups collide across
  // channels, and a zero address now and then gives an add that stays free
  function automatic in_t fresh_link();
    in_t c;
    c.cmd        = CMD_ADD;
    c.local_chan = 6'($urandom_range(0, 63));
    case ($urandom_range(0, 15))
      0:          c.peer_address = ADDR_NONE;
      1, 2, 3, 4: c.peer_address = 24'($urandom_range(1, 15));
      default:    c.peer_address = 24'($urandom());
    endcase
    c.peer_chan = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom());
    return c;
  endfunction

  // mode 0 fills the table, 1 empties it, 2 mostly looks up, 3 mixes
  function automatic in_t make_cmd(int unsigned mode);
    int unsigned add_w [4] = '{70, 15, 20, 35};
    int unsigned rem_w [4] = '{10, 60, 15, 30};
    int unsigned r;
    int unsigned s;
    cmd_t        kind;
    in_t         c;
    r = $urandom_range(0, 99);
    if (r < add_w[mode])                    kind = CMD_ADD;
    else if (r < add_w[mode] + rem_w[mode]) kind = CMD_REMOVE;
    else if (r < 97)                        kind = CMD_LOOKUP;
    else                                    kind = CMD_NOP;
    case (kind)
      CMD_ADD: begin
        // a repeat of a pooled link stores a duplicate
        if (link_pool.size() > 0 && $urandom_range(0, 7) == 0)
          c = link_pool[$urandom_range(0, link_pool.size() - 1)];
        else
          c = fresh_link();
        link_pool.push_back(c);
        if (link_pool.size() > 48) void'(link_pool.pop_front());
      end
      CMD_REMOVE, CMD_LOOKUP: begin
        s = $urandom_range(0, 9);
        if (s < 7 && link_pool.size() > 0) begin
          c = link_pool[$urandom_range(0, link_pool.size() - 1)];
        end else if (s < 8) begin
          c = link_cmd(kind, 6'($urandom_range(0, 63)), ADDR_NONE, 8'd0);
        end else if (s == 8 && link_pool.size() > 0) begin
          // near miss: one field one bit off a known link
          c = link_pool[$urandom_range(0, link_pool.size() - 1)];
          case ($urandom_range(0, 2))
            0:       c.local_chan[$urandom_range(0, 5)]    ^= 1'b1;
            1:       c.peer_address[$urandom_range(0, 23)] ^= 1'b1;
            default: c.peer_chan[$urandom_range(0, 7)]     ^= 1'b1;
          endcase
        end else begin
          c = fresh_link();
        end
      end
      default: begin
        c = link_cmd(kind, 6'($urandom()), 24'($urandom()), 8'($urandom()));
      end
    endcase
    c.cmd = kind;
    return c;
  endfunction

  // Offers one command beat after a random gap and returns at the edge that
  // takes it. Valid is left high, so a gapless next beat simply replaces the
  // payload at the following falling edge.
  task automatic send_cmd(in_t c);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // sender pause: nothing offered until every expected result is back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Result side. A random wait is drawn per beat; once, mid-run, the receiver
  // holds off while the sender keeps offering, so the output register and
  // the scan both fill and in_stall has to rise.
  initial begin : result_sink
    int unsigned w;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!long_hold_done && rx_beats >= 470) begin
        w              = 300;
        long_hold_done = 1'b1;
      end else begin
        w = quiet ? 0 : $urandom_range(0, 7);
      end
      if (w > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (w - 1) @(negedge clk);
        @(negedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      rx_beats++;
    end
  end

  initial begin : stimulus
    in_t         directed [$];
    int unsigned blk;
    int unsigned n;
    int unsigned mode;
    in_valid = 1'b0;
    in_data  = '0;
    rst_n    = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed beats; the comments give the table contents they rely on.
    directed = '{
      link_cmd(CMD_LOOKUP, 6'd0,  ADDR_NONE,    8'h00),  // local id, 0xC0
      link_cmd(CMD_LOOKUP, 6'd63, ADDR_NONE,    8'h00),  // local id 0xFF, found
      link_cmd(CMD_REMOVE, 6'd5,  ADDR_NONE,    8'h00),  // local id cannot go
      link_cmd(CMD_NOP,    6'd63, 24'hFFFFFF,   8'hFF),  // unused command
      link_cmd(CMD_NOP,    6'd0,  ADDR_NONE,    8'h00),
      link_cmd(CMD_REMOVE, 6'd1,  24'h123456,   8'h07),  // miss on empty table
      link_cmd(CMD_LOOKUP, 6'd1,  24'h123456,   8'h07),  // miss
      link_cmd(CMD_ADD,    6'd63, 24'hFFFFFF,   8'hFF),  // slot 0, sets dirty
      link_cmd(CMD_ADD,    6'd0,  24'h000001,   8'h00),  // slot 1
      link_cmd(CMD_ADD,    6'd63, 24'hFFFFFF,   8'hFF),  // duplicate in slot 2
      link_cmd(CMD_LOOKUP, 6'd63, 24'hFFFFFF,   8'hFF),  // lowest copy, slot 0
      link_cmd(CMD_ADD,    6'd9,  ADDR_NONE,    8'h5A),  // zero address, slot 3
      link_cmd(CMD_LOOKUP, 6'd9,  ADDR_NONE,    8'h5A),  // still matches slot 3
      link_cmd(CMD_ADD,    6'd2,  24'hABCDEF,   8'h11),  // slot 3 was free
      link_cmd(CMD_LOOKUP, 6'd9,  ADDR_NONE,    8'h5A),  // overwritten, miss
      link_cmd(CMD_REMOVE, 6'd63, 24'hFFFFFF,   8'hFF),  // clears slot 0
      link_cmd(CMD_LOOKUP, 6'd63, 24'hFFFFFF,   8'hFF),  // duplicate, slot 2
      link_cmd(CMD_REMOVE, 6'd63, 24'hFFFFFF,   8'hFF),  // clears slot 2
      link_cmd(CMD_REMOVE, 6'd63, 24'hFFFFFF,   8'hFF),  // gone, miss
      link_cmd(CMD_ADD,    6'd42, 24'h555555,   8'hAA),  // slot 0 again
      link_cmd(CMD_ADD,    6'd21, 24'hAAAAAA,   8'h55),  // slot 2 again
      link_cmd(CMD_LOOKUP, 6'd21, 24'hAAAAAA,   8'h55),
      link_cmd(CMD_LOOKUP, 6'd0,  24'h000001,   8'h00)   // slot 1
    };
    foreach (directed[i]) send_cmd(directed[i]);
    drain_results();

    // Random phases of 50 beats. The first two fill the table past full and
    // then empty it; after that the mode is drawn. Every fourth phase ends
    // with the sender waiting for all results.
    for (blk = 0; blk < 21; blk++) begin
      mode  = (blk < 2) ? blk : $urandom_range(0, 3);
      quiet <= ($urandom_range(0, 3) == 0);
      for (n = 0; n < 50; n++) send_cmd(make_cmd(mode));
      if (blk % 4 == 3) drain_results();
    end
    quiet <= 1'b0;

    drain_results();
    // let any stray beat surface: well past the longest scan latency
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin : watchdog
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/plt_pkg.sv
hw/rtl/plt_store.sv
hw/rtl/peer_link_table.sv
hw/rtl/plt_checker.sv
verif/plt_checker.sv
verif/tb_top.sv
